@@ sv/mcs_pkg.sv @@
// shared types and constants for the mask centroid steering unit
// no dependencies
`default_nettype none
package mcs_pkg;
	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 512;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int SUM_W = 29;
	localparam int CNT_W = 20;
	localparam int CTR_W = $clog2(SUM_W);
	localparam int REG_W = 10;
	localparam int IDX_W = 2;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CTR_W-1:0] DIV_LAST = CTR_W'(SUM_W - 1);

	localparam logic [IDX_W-1:0] REG_IMAGE_CENTER = 2'd0;
	localparam logic [IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND = 2'd2;

	localparam logic [REG_W-1:0] IMAGE_CENTER_RST = 10'd320;
	localparam logic [REG_W-1:0] JUMP_THRESHOLD_RST = 10'd60;
	localparam logic [REG_W-1:0] DEAD_BAND_RST = 10'd10;

	typedef enum logic [1:0] {
		DIR_STRAIGHT = 2'd0,
		DIR_LEFT = 2'd1,
		DIR_RIGHT = 2'd2
	} dir_t;

	typedef struct packed {
		logic acc_en;
		logic div_start;
		logic div_step;
		logic out_load;
	} mcs_cmd_t;

	typedef struct packed {
		logic div_last;
	} mcs_stat_t;
endpackage
`default_nettype wire

@@ sv/mcs_ctrl.sv @@
// controller state machine: handshakes and sequencing of accumulate, divide, decide
// depends on mcs_pkg
`default_nettype none
module mcs_ctrl import mcs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic frame_end,
	output logic out_valid,
	input wire logic out_ready,
	output mcs_cmd_t cmd,
	input wire mcs_stat_t stat
);
	typedef enum logic [2:0] {
		ST_ACC = 3'b001,
		ST_DIV = 3'b010,
		ST_DEC = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q, out_valid_d;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_ACC);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q;
		cmd = '0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			ST_ACC: begin
				if (in_valid) begin
					cmd.acc_en = 1'b1;
					if (frame_end) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					state_d = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end
endmodule
`default_nettype wire

@@ sv/mcs_datapath.sv @@
// datapath: config registers, accumulators, restoring divider, steering decision
// depends on mcs_pkg
`default_nettype none
module mcs_datapath import mcs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [REG_W-1:0] cfg_data,
	input wire logic [7:0] pixel_value,
	input wire logic row_end,
	input wire logic frame_end,
	input wire mcs_cmd_t cmd,
	output mcs_stat_t stat,
	output logic [REG_W-1:0] center_column,
	output logic [1:0] direction
);
	logic [REG_W-1:0] image_center_q, jump_threshold_q, dead_band_q;
	logic [COL_W-1:0] col_q;
	logic [SUM_W-1:0] sum_q, sum_next;
	logic [CNT_W-1:0] cnt_q, cnt_next;
	logic [SUM_W:0] sum_try;
	logic take;

	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q, divisor_q;
	logic [CTR_W-1:0] ctr_q;
	logic zero_q;
	logic [CNT_W:0] trial, diff;
	logic fits;

	logic [REG_W-1:0] prev_q, center_column_q;
	dir_t dir_q, dir_next;
	logic [REG_W-1:0] center;
	logic signed [REG_W+1:0] jump, jump_abs, off;
	logic keep;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_center_q <= IMAGE_CENTER_RST;
			jump_threshold_q <= JUMP_THRESHOLD_RST;
			dead_band_q <= DEAD_BAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_CENTER: image_center_q <= cfg_data;
				REG_JUMP_THRESHOLD: jump_threshold_q <= cfg_data;
				REG_DEAD_BAND: dead_band_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulate with saturation guard
	assign sum_try = {1'b0, sum_q} + (SUM_W+1)'(col_q);
	assign take = (pixel_value != 8'd0) && (cnt_q != CNT_MAX) && !sum_try[SUM_W];
	assign sum_next = take ? sum_try[SUM_W-1:0] : sum_q;
	assign cnt_next = take ? cnt_q + CNT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
		end else if (cmd.acc_en) begin
			if (frame_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
			if (row_end || frame_end || col_q == COL_LAST) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits = trial >= {1'b0, divisor_q};
	assign diff = trial - {1'b0, divisor_q};
	assign stat.div_last = (ctr_q == DIV_LAST);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= sum_next;
			divisor_q <= cnt_next;
			zero_q <= (cnt_next == '0);
			rem_q <= '0;
			ctr_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			ctr_q <= ctr_q + CTR_W'(1);
		end
	end

	// steering decision
	assign center = zero_q ? '0 : quo_q[REG_W-1:0];
	assign jump = $signed({2'b00, center}) - $signed({2'b00, prev_q});
	assign jump_abs = jump[REG_W+1] ? -jump : jump;
	assign keep = (center == '0) || (jump_abs > $signed({2'b00, jump_threshold_q}));
	assign off = $signed({2'b00, center}) - $signed({2'b00, image_center_q});

	always_comb begin
		dir_next = DIR_STRAIGHT;
		if (keep) begin
			dir_next = dir_q;
		end else if (off > $signed({2'b00, dead_band_q})) begin
			dir_next = DIR_RIGHT;
		end else if (-off > $signed({2'b00, dead_band_q})) begin
			dir_next = DIR_LEFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= IMAGE_CENTER_RST;
			dir_q <= DIR_STRAIGHT;
		end else if (cmd.out_load) begin
			dir_q <= dir_next;
			if (!keep && dir_next != DIR_STRAIGHT) begin
				prev_q <= center;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			center_column_q <= center;
		end
	end

	assign center_column = center_column_q;
	assign direction = dir_q;
endmodule
`default_nettype wire

@@ sv/mask_centroid_steering_unit.sv @@
// top level of the mask centroid steering unit
// depends on mcs_pkg, mcs_ctrl and mcs_datapath
`default_nettype none
// usage
// - pixel channel (in_valid/in_ready, pixel_value, row_end, frame_end) takes one mask
//   pixel per cycle in raster order while a frame is being accumulated
// - a request with frame_end set closes the frame; the unit then runs a restoring
//   divider of the column sum by the marked-pixel count, one quotient bit per cycle
// - after the pixels of a frame come the divider steps and the decision state,
//   during which in_ready is low
// - the result is offered once the divider has finished and the output register is free
// - the next frame's pixels are taken as soon as the result sits in the output
//   register, even if the receiver has not yet taken it
// - result channel (out_valid/out_ready, center_column, direction) gives one request
//   per frame; while the receiver stalls, a finished frame waits in the decision
//   state with in_ready low, so no further pixels are taken until the output frees
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; index
//   0 image_center, 1 jump_threshold, 2 dead_band, 3 ignored
// - reset clears the accumulators, sets direction straight, the previous center to
//   320 and the config registers to 320, 60 and 10
module mask_centroid_steering_unit import mcs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [REG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] pixel_value,
	input wire logic row_end,
	input wire logic frame_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic [REG_W-1:0] center_column,
	output logic [1:0] direction
);
	mcs_cmd_t cmd;
	mcs_stat_t stat;

	// config writes are accepted at any time
	assign cfg_ready = 1'b1;

	// sequencing and handshakes
	mcs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.stat(stat)
	);

	// accumulators, divider and decision logic
	mcs_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_value(pixel_value),
		.row_end(row_end),
		.frame_end(frame_end),
		.cmd(cmd),
		.stat(stat),
		.center_column(center_column),
		.direction(direction)
	);
endmodule
`default_nettype wire
